// File: rtl/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared types and memory map constants for the memory map bus decoder.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  // memory map boundaries
  localparam logic [15:0] BOOT_END    = 16'h0100;
  localparam logic [15:0] VRAM_BASE   = 16'h8000;
  localparam logic [15:0] XRAM_BASE   = 16'hA000;
  localparam logic [15:0] WRAM_BASE   = 16'hC000;
  localparam logic [15:0] ECHO_BASE   = 16'hE000;
  localparam logic [15:0] ECHO_END    = 16'hFE00;
  localparam logic [15:0] ECHO_OFFSET = 16'h2000;
  localparam logic [15:0] OAM_BASE    = 16'hFE00;
  localparam logic [15:0] OAM_END     = 16'hFEA0;
  localparam logic [15:0] IO_BASE     = 16'hFF00;
  localparam logic [15:0] HRAM_BASE   = 16'hFF80;
  localparam logic [15:0] IE_ADDR     = 16'hFFFF;

  // local storage sizes
  localparam int WRAM_DEPTH = 8192;
  localparam int HRAM_DEPTH = 127;
  localparam int WRAM_AW    = 13;
  localparam int HRAM_AW    = 7;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

  typedef enum logic [2:0] {
    TGT_LOCAL = 3'd0,
    TGT_BOOT  = 3'd1,
    TGT_CART  = 3'd2,
    TGT_VIDEO = 3'd3,
    TGT_IO    = 3'd4,
    TGT_IE    = 3'd5
  } target_t;

  typedef enum logic [1:0] {
    RD_CONST = 2'd0,
    RD_WRAM  = 2'd1,
    RD_HRAM  = 2'd2
  } rd_src_t;

  // decode result for one transaction
  typedef struct packed {
    target_t     target;
    logic [15:0] taddr;
    logic        fwd_write;
    logic [7:0]  fwd_data;
    rd_src_t     rd_src;
    logic [7:0]  rd_const;
    logic        wram_en;
    logic        wram_we;
    logic        hram_en;
    logic        hram_we;
    logic        clear_boot;
  } dec_t;

endpackage

// File: rtl/mmbd_ram.sv
// ----------------------------------------------------------------------------
// mmbd_ram
// Single-port byte RAM with registered read data.
// ----------------------------------------------------------------------------
module mmbd_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/mmbd_decode.sv
// ----------------------------------------------------------------------------
// mmbd_decode
// Address decode of one bus transaction against the memory map.
// ----------------------------------------------------------------------------
module mmbd_decode (
  input  logic           op,
  input  logic [15:0]    addr,
  input  logic [7:0]     wdata,
  input  logic           dma_active,
  input  logic           boot,
  input  logic           cart_present,
  output mmbd_pkg::dec_t dec
);
  import mmbd_pkg::*;

  logic in_echo;
  logic in_hram;
  logic blocked;
  logic cart_area;

  assign in_echo   = (addr >= ECHO_BASE) && (addr < ECHO_END);
  assign in_hram   = (addr >= HRAM_BASE) && (addr != IE_ADDR);
  assign blocked   = dma_active && !in_hram;
  assign cart_area = (addr < VRAM_BASE) || ((addr >= XRAM_BASE) && (addr < WRAM_BASE));

  always_comb begin
    dec          = '0;
    dec.target   = TGT_LOCAL;
    dec.rd_src   = RD_CONST;
    dec.taddr    = in_echo ? (addr - ECHO_OFFSET) : addr;

    if (blocked) begin
      dec.rd_const = op ? 8'h00 : OPEN_BUS;
    end else if (cart_area) begin
      if (!op) begin
        dec.clear_boot = boot && (addr == BOOT_END);
        if (boot && (addr < BOOT_END)) begin
          dec.target = TGT_BOOT;
        end else if (cart_present) begin
          dec.target = TGT_CART;
        end
      end else if (!boot && cart_present) begin
        dec.target    = TGT_CART;
        dec.fwd_write = 1'b1;
      end
    end else if ((addr < XRAM_BASE) || ((addr >= OAM_BASE) && (addr < OAM_END))) begin
      dec.target    = TGT_VIDEO;
      dec.fwd_write = op;
    end else if ((addr >= IO_BASE) && (addr < HRAM_BASE)) begin
      dec.target    = TGT_IO;
      dec.fwd_write = op;
    end else if (addr == IE_ADDR) begin
      dec.target    = TGT_IE;
      dec.fwd_write = op;
    end else if (addr >= HRAM_BASE) begin
      dec.hram_en = 1'b1;
      dec.hram_we = op;
      dec.rd_src  = op ? RD_CONST : RD_HRAM;
    end else if (addr >= OAM_END) begin
      // unusable region
      dec.rd_const = op ? 8'h00 : OPEN_BUS;
    end else begin
      // work ram and its echo
      dec.wram_en = 1'b1;
      dec.wram_we = op;
      dec.rd_src  = op ? RD_CONST : RD_WRAM;
    end

    dec.fwd_data = dec.fwd_write ? wdata : 8'h00;
  end

endmodule

// File: rtl/memory_map_bus_decoder_top.sv
// ----------------------------------------------------------------------------
// memory_map_bus_decoder_top
// Memory map decoder for an 8-bit handheld bus: answers work ram, high ram
// and fixed regions locally and forwards the rest as a target code.
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                      content
//   in_       slave      in_tvalid/tready/tdata/user one bus access
//   out_      master     out_tvalid/tready/tdata    one decoded result
//   cfg_      write      cfg_wen/cfg_wdata          cart_present register
//
// from input transaction to result there is an input register, then decode
// plus the ram access into the output register. one transaction per cycle is
// sustained while out_tready is high; the single-port rams are accessed once per item.
// rst_n (synchronous, active low) clears the valid flags, sets the boot
// overlay and clears cart_present; ram contents are undefined until written.
// a stall on out_tready holds both stages and the ram read data in place.
//
module memory_map_bus_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wen,
  input  logic        cfg_wdata,    // cart_present
  // access stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // addr[15:0], wdata[23:16], dma_active[24], zero pad
  input  logic        in_tuser,     // op: 0 read, 1 write
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata     // target[2:0], target_addr[18:3], fwd_write[19],
                                    // fwd_data[27:20], read_data[35:28], booting[36], pad
);
  import mmbd_pkg::*;

  // configuration register
  logic cart_present_r;

  // boot rom overlay flag
  logic boot_r;
  logic boot_nxt;

  // input stage
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_wdata_r;
  logic        s1_dma_r;

  // output stage
  logic        s2_valid_r;
  target_t     s2_target_r;
  logic [15:0] s2_taddr_r;
  logic        s2_fwd_write_r;
  logic [7:0]  s2_fwd_data_r;
  rd_src_t     s2_rd_src_r;
  logic [7:0]  s2_rd_const_r;
  logic        s2_booting_r;

  dec_t       dec;
  logic       advance;
  logic       in_accept;
  logic [7:0] wram_q;
  logic [7:0] hram_q;
  logic [7:0] read_data;

  // the input stage moves on when the output stage is empty or being drained
  assign advance   = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_present_r <= 1'b0;
    end else if (cfg_wen) begin
      cart_present_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_tuser;
      s1_addr_r  <= in_tdata[15:0];
      s1_wdata_r <= in_tdata[23:16];
      s1_dma_r   <= in_tdata[24];
    end
  end

  mmbd_decode u_decode (
    .op           (s1_op_r),
    .addr         (s1_addr_r),
    .wdata        (s1_wdata_r),
    .dma_active   (s1_dma_r),
    .boot         (boot_r),
    .cart_present (cart_present_r),
    .dec          (dec)
  );

  // a read of the first cartridge byte unmaps the boot rom for good
  assign boot_nxt = (advance && dec.clear_boot) ? 1'b0 : boot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r <= 1'b1;
    end else begin
      boot_r <= boot_nxt;
    end
  end

  // rams are touched only when the item moves into the output stage, so
  // read data stays put while the result is stalled
  mmbd_ram #(
    .DEPTH (WRAM_DEPTH),
    .WIDTH (8),
    .AW    (WRAM_AW)
  ) u_wram (
    .clk   (clk),
    .en    (advance && dec.wram_en),
    .we    (dec.wram_we),
    .addr  (s1_addr_r[WRAM_AW-1:0]),
    .wdata (s1_wdata_r),
    .rdata (wram_q)
  );

  mmbd_ram #(
    .DEPTH (HRAM_DEPTH),
    .WIDTH (8),
    .AW    (HRAM_AW)
  ) u_hram (
    .clk   (clk),
    .en    (advance && dec.hram_en),
    .we    (dec.hram_we),
    .addr  (s1_addr_r[HRAM_AW-1:0]),
    .wdata (s1_wdata_r),
    .rdata (hram_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= 1'b1;
    end else if (out_tready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_target_r    <= dec.target;
      s2_taddr_r     <= dec.taddr;
      s2_fwd_write_r <= dec.fwd_write;
      s2_fwd_data_r  <= dec.fwd_data;
      s2_rd_src_r    <= dec.rd_src;
      s2_rd_const_r  <= dec.rd_const;
      s2_booting_r   <= boot_nxt;
    end
  end

  // pick the local read byte from the registered ram outputs
  always_comb begin
    unique case (s2_rd_src_r)
      RD_WRAM: read_data = wram_q;
      RD_HRAM: read_data = hram_q;
      default: read_data = s2_rd_const_r;
    endcase
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {3'b000, s2_booting_r, read_data, s2_fwd_data_r,
                       s2_fwd_write_r, s2_taddr_r, s2_target_r};

`ifndef SYNTHESIS
  // once the boot rom is unmapped it stays unmapped
  a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !boot_r |=> !boot_r)
    else $error("boot overlay came back after being cleared");

  // a forwarded write always names an outside target
  a_fwd_has_target: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_fwd_write_r |-> s2_target_r != TGT_LOCAL)
    else $error("forwarded write with local target");

  // work ram is never accessed while dma blocks the bus
  a_dma_no_wram: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec.wram_en |-> !s1_dma_r)
    else $error("work ram accessed during dma");

  // a local ram read shows up only as a local answer
  a_ram_read_local: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && (s2_rd_src_r != RD_CONST) |-> s2_target_r == TGT_LOCAL)
    else $error("ram read data on a forwarded transaction");
`endif

endmodule

// File: tb/memory_map_bus_decoder_top_test.sv
// ----------------------------------------------------------------------------
// memory_map_bus_decoder_top_test
// Self-checking bench for the memory map bus decoder. A queue of bus accesses
// feeds a stream driver; a local decoder model predicts every result and a
// monitor compares each output transaction field by field, in order. Random
// idle bursts on both sides, cartridge presence switched between phases.
// ----------------------------------------------------------------------------
module memory_map_bus_decoder_top_test;
  import mmbd_pkg::*;

  // access kinds as carried on in_tuser
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // generous bound on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 250;
  localparam int MAX_REPORTS   = 10;

  // one bus access as it enters the decoder
  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        dma;
  } bus_access_t;

  // one decoded result as it leaves the decoder
  typedef struct {
    target_t     target;
    logic [15:0] taddr;
    logic        fwd_write;
    logic [7:0]  fwd_data;
    logic [7:0]  read_data;
    logic        booting;
  } decode_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  // accesses waiting for the driver, results waiting for the monitor
  bus_access_t    pending_accesses[$];
  decode_result_t expected_results[$];

  // decoder model state, updated in acceptance order
  logic       boot_flag_model = 1'b1;
  logic       cart_flag_model = 1'b0;
  logic [7:0] wram_model[WRAM_DEPTH];
  logic [7:0] hram_model[HRAM_DEPTH];

  // which ram bytes the stimulus has written, so no read hits an unwritten byte
  bit wram_written[WRAM_DEPTH];
  bit hram_written[HRAM_DEPTH];
  int wram_written_list[$];
  int hram_written_list[$];

  bit          stall_enable = 1'b0;
  int          in_gap       = 0;
  int          out_gap      = 0;
  bus_access_t active_access;
  int          error_count    = 0;
  int          mismatch_count = 0;
  int          result_count   = 0;
  int          cycle_count    = 0;

  memory_map_bus_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // addr[15:0], wdata[23:16], dma_active[24], zero pad
    .in_tuser   (in_tuser),     // op: 0 read, 1 write
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // target, target_addr, fwd_write, fwd_data, read_data,
                                // booting, pad
  );

  always #5 clk = ~clk;

  // decode one access the way the block should, updating the model state
  function automatic decode_result_t decode_access(bus_access_t acc);
    decode_result_t r;
    logic [15:0]    a;
    logic [7:0]     rd;
    int             hidx;
    a           = acc.addr;
    r.target    = TGT_LOCAL;
    r.taddr     = a;
    r.fwd_write = 1'b0;
    rd          = 8'h00;
    // echo space folds onto work ram for every kind of answer
    if (a >= ECHO_BASE && a < ECHO_END)
      r.taddr = a - ECHO_OFFSET;
    if (acc.dma && !(a >= HRAM_BASE && a < IE_ADDR)) begin
      // dma blocks all but high ram: reads float, writes vanish
      rd = OPEN_BUS;
    end else if (a < VRAM_BASE || (a >= XRAM_BASE && a < WRAM_BASE)) begin
      if (acc.op == OP_READ) begin
        // leaving the boot rom: the read of 0x0100 drops the overlay
        if (boot_flag_model && a == BOOT_END)
          boot_flag_model = 1'b0;
        if (boot_flag_model && a < BOOT_END)
          r.target = TGT_BOOT;
        else if (cart_flag_model)
          r.target = TGT_CART;
      end else if (!boot_flag_model && cart_flag_model) begin
        r.target    = TGT_CART;
        r.fwd_write = 1'b1;
      end
    end else if (a < XRAM_BASE || (a >= OAM_BASE && a < OAM_END)) begin
      r.target    = TGT_VIDEO;
      r.fwd_write = acc.op;
    end else if (a >= IO_BASE && a < HRAM_BASE) begin
      r.target    = TGT_IO;
      r.fwd_write = acc.op;
    end else if (a == IE_ADDR) begin
      r.target    = TGT_IE;
      r.fwd_write = acc.op;
    end else if (a >= HRAM_BASE) begin
      hidx = int'(a - HRAM_BASE);
      if (acc.op == OP_WRITE)
        hram_model[hidx] = acc.wdata;
      else
        rd = hram_model[hidx];
    end else if (a >= OAM_END) begin
      rd = OPEN_BUS;
    end else begin
      // work ram, echo already folded into taddr
      if (acc.op == OP_WRITE)
        wram_model[r.taddr[WRAM_AW-1:0]] = acc.wdata;
      else
        rd = wram_model[r.taddr[WRAM_AW-1:0]];
    end
    r.fwd_data  = r.fwd_write ? acc.wdata : 8'h00;
    r.read_data = (r.target == TGT_LOCAL && acc.op == OP_READ) ? rd : 8'h00;
    r.booting   = boot_flag_model;
    return r;
  endfunction

  // queue one access; a read of a ram byte never written becomes a write
  task automatic queue_access(logic op, logic [15:0] addr, logic [7:0] wdata, logic dma);
    bus_access_t acc;
    bit          wram_hit;
    bit          hram_hit;
    int          widx;
    int          hidx;
    wram_hit = !dma && addr >= WRAM_BASE && addr < ECHO_END;
    hram_hit = addr >= HRAM_BASE && addr < IE_ADDR;
    widx     = int'(addr) & (WRAM_DEPTH - 1);
    hidx     = int'(addr) - int'(HRAM_BASE);
    if (op == OP_READ && ((wram_hit && !wram_written[widx]) ||
                          (hram_hit && !hram_written[hidx])))
      op = OP_WRITE;
    if (op == OP_WRITE && wram_hit && !wram_written[widx]) begin
      wram_written[widx] = 1'b1;
      wram_written_list.push_back(widx);
    end
    if (op == OP_WRITE && hram_hit && !hram_written[hidx]) begin
      hram_written[hidx] = 1'b1;
      hram_written_list.push_back(hidx);
    end
    acc.op    = op;
    acc.addr  = addr;
    acc.wdata = wdata;
    acc.dma   = dma;
    pending_accesses.push_back(acc);
  endtask

  // random access weighted across the regions of the map
  task automatic queue_random_access();
    logic        op;
    logic        dma;
    logic [15:0] addr;
    int          pick;
    int          idx;
    op   = 1'($urandom);
    dma  = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    addr = 16'($urandom);
    if (pick < 10) begin
      // anywhere in the map, keeps every address bit toggling
    end else if (pick < 40) begin
      // reads mostly go back to bytes already written
      if (op == OP_READ && wram_written_list.size() != 0)
        idx = wram_written_list[$urandom_range(0, wram_written_list.size() - 1)];
      else
        idx = $urandom_range(0, WRAM_DEPTH - 1);
      if (idx < int'(ECHO_END - ECHO_BASE) && $urandom_range(0, 3) == 0)
        addr = 16'(int'(ECHO_BASE) + idx);
      else
        addr = 16'(int'(WRAM_BASE) + idx);
    end else if (pick < 55) begin
      if (op == OP_READ && hram_written_list.size() != 0)
        idx = hram_written_list[$urandom_range(0, hram_written_list.size() - 1)];
      else
        idx = $urandom_range(0, HRAM_DEPTH - 1);
      addr = 16'(int'(HRAM_BASE) + idx);
    end else if (pick < 70) begin
      // cartridge rom or external ram
      if ($urandom_range(0, 3) == 0)
        addr = XRAM_BASE + 16'($urandom_range(0, 16'h1FFF));
      else
        addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 80) begin
      if ($urandom_range(0, 1) == 0)
        addr = VRAM_BASE + 16'($urandom_range(0, 16'h1FFF));
      else
        addr = OAM_BASE + 16'($urandom_range(0, 159));
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) == 0)
        addr = IE_ADDR;
      else
        addr = IO_BASE + 16'($urandom_range(0, 127));
    end else if (pick < 95) begin
      // unusable hole above object memory
      addr = OAM_END + 16'($urandom_range(0, 95));
    end else begin
      // boot rom window and its exit address
      addr = 16'($urandom_range(0, 16'h0101));
    end
    queue_access(op, addr, 8'($urandom), dma);
  endtask

  // let the pipe drain completely and the clock run on past it; the drain is
  // checked at the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_accesses.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // cartridge presence only changes with nothing in flight
  task automatic write_cart_present(logic value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cart_flag_model = value;
  endtask

  task automatic report_error(string what, int expected_val, int actual_val);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("result %0d: %s expected %0h actual %0h", result_count, what,
               expected_val, actual_val);
  endtask

  // input driver: one access per transaction, idle bursts between them when stalls are enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      // prediction runs in acceptance order, which is the decode order
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_access(active_access));
      if (!in_tvalid || in_tready) begin
        if (in_gap == 0 && stall_enable && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 7);
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          active_access = pending_accesses.pop_front();
          in_tdata  <= {7'd0, active_access.dma, active_access.wdata, active_access.addr};
          in_tuser  <= active_access.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.target    = target_t'(out_tdata[2:0]);
        got.taddr     = out_tdata[18:3];
        got.fwd_write = out_tdata[19];
        got.fwd_data  = out_tdata[27:20];
        got.read_data = out_tdata[35:28];
        got.booting   = out_tdata[36];
        if (expected_results.size() == 0) begin
          report_error("unexpected result, target_addr", 0, got.taddr);
        end else begin
          want = expected_results.pop_front();
          if (got.target !== want.target)
            report_error("target", want.target, got.target);
          if (got.taddr !== want.taddr)
            report_error("target_addr", want.taddr, got.taddr);
          if (got.fwd_write !== want.fwd_write)
            report_error("fwd_write", want.fwd_write, got.fwd_write);
          if (got.fwd_data !== want.fwd_data)
            report_error("fwd_data", want.fwd_data, got.fwd_data);
          if (got.read_data !== want.read_data)
            report_error("read_data", want.read_data, got.read_data);
          if (got.booting !== want.booting)
            report_error("booting", want.booting, got.booting);
        end
        result_count++;
      end
      // back-pressure in bursts
      if (out_gap == 0 && stall_enable && $urandom_range(0, 5) == 0)
        out_gap = $urandom_range(1, 7);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on the cycle count
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no cartridge yet, boot overlay still mapped
    queue_access(OP_READ,  16'h0000, 8'h00, 1'b0);  // boot rom low edge
    queue_access(OP_READ,  16'h00FF, 8'h00, 1'b0);  // boot rom high edge
    queue_access(OP_WRITE, 16'h0050, 8'hA5, 1'b0);  // dropped while booting
    queue_access(OP_READ,  16'h0200, 8'h00, 1'b0);  // no cartridge reads zero
    queue_access(OP_READ,  16'hB000, 8'h00, 1'b0);  // external ram, no cartridge
    queue_access(OP_READ,  16'h0100, 8'h00, 1'b1);  // blocked by dma, overlay stays
    write_cart_present(1'b1);

    // cartridge inserted: boot exit, every region, dma blocking
    queue_access(OP_WRITE, 16'h1234, 8'h3C, 1'b0);  // cart write dropped while booting
    queue_access(OP_READ,  16'h00FF, 8'h00, 1'b0);  // overlay wins over cartridge
    queue_access(OP_READ,  16'h0100, 8'h00, 1'b0);  // clears the overlay
    queue_access(OP_READ,  16'h0000, 8'h00, 1'b0);  // now the cartridge
    queue_access(OP_WRITE, 16'h7FFF, 8'hFF, 1'b0);
    queue_access(OP_WRITE, 16'hA000, 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'h8000, 8'h80, 1'b0);
    queue_access(OP_READ,  16'h9FFF, 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'hC000, 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'hFDFF, 8'hFF, 1'b0);  // echo top lands on 0xDDFF
    queue_access(OP_READ,  16'hDDFF, 8'h00, 1'b0);
    queue_access(OP_READ,  16'hE000, 8'h00, 1'b0);  // echo of 0xC000
    queue_access(OP_WRITE, 16'hFE00, 8'h5A, 1'b0);
    queue_access(OP_READ,  16'hFEA0, 8'h00, 1'b0);  // unusable region
    queue_access(OP_WRITE, 16'hFEFF, 8'h77, 1'b0);
    queue_access(OP_WRITE, 16'hFF00, 8'h01, 1'b0);
    queue_access(OP_READ,  16'hFF7F, 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'hFF80, 8'hC3, 1'b0);
    queue_access(OP_WRITE, 16'hFFFE, 8'h3C, 1'b1);  // high ram stays reachable under dma
    queue_access(OP_READ,  16'hFFFE, 8'h00, 1'b1);
    queue_access(OP_READ,  16'hFF80, 8'h00, 1'b0);
    queue_access(OP_WRITE, 16'hFFFF, 8'h1F, 1'b0);
    queue_access(OP_READ,  16'hFFFF, 8'h00, 1'b1);  // interrupt enable blocked by dma
    queue_access(OP_WRITE, 16'hC001, 8'h99, 1'b1);  // work ram write dropped by dma
    wait_idle();

    // random phases, cartridge toggled in between, no idling in the second and the last one
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase != 0)
        write_cart_present(phase % 2 == 0);
      stall_enable = (phase != 1) && (phase != RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_random_access();
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      report_error("results never arrived", expected_results.size(), 0);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
